[hw/rtl/bcc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the button click classifier
// Press states, event codes, register indexes and the channel structs.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int CountWidth    = 16;
   localparam int ThreshWidth   = 16;
   localparam int CmpWidth      = (CountWidth > ThreshWidth) ? CountWidth : ThreshWidth;
   localparam int KeyEventWidth = 3;
   localparam int CsrIndexWidth = 2;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // item modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG         = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SUPER_LONG   = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DOUBLE_WIN   = 2'd3;

   // register reset values
   localparam logic [ThreshWidth-1:0] DEBOUNCE_RESET    = 16'd20;
   localparam logic [ThreshWidth-1:0] LONG_RESET        = 16'd2000;
   localparam logic [ThreshWidth-1:0] SUPER_LONG_RESET  = 16'd5000;
   localparam logic [ThreshWidth-1:0] DOUBLE_WIN_RESET  = 16'd350;

   typedef enum logic [3:0] {
      ST_WAIT         = 4'd0,
      ST_DEBOUNCE     = 4'd1,
      ST_PRESSED      = 4'd2,
      ST_RELEASED     = 4'd3,
      ST_CHECK_DOUBLE = 4'd4,
      ST_SUPER_LONG   = 4'd5,
      ST_LONG         = 4'd6,
      ST_SHORT        = 4'd7,
      ST_WAIT_RELEASE = 4'd8,
      ST_DOUBLE       = 4'd9
   } press_state_type;

   typedef enum logic [KeyEventWidth-1:0] {
      EV_NONE       = 3'd0,
      EV_PENDING    = 3'd1,
      EV_SHORT      = 3'd2,
      EV_LONG       = 3'd3,
      EV_SUPER_LONG = 3'd4,
      EV_DOUBLE     = 3'd5
   } key_event_type;

   typedef struct packed {
      logic [ThreshWidth-1:0] debounce_ticks;
      logic [ThreshWidth-1:0] long_ticks;
      logic [ThreshWidth-1:0] super_long_ticks;
      logic [ThreshWidth-1:0] double_window_ticks;
   } csr_type;

   typedef struct packed {
      logic valid;
      logic mode;
      logic pressed;
   } step_type;

   typedef struct packed {
      logic          valid;
      key_event_type key_event;
   } result_type;

endpackage
`default_nettype wire

[hw/rtl/bcc_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_csr: threshold registers
// Four write-only 16-bit thresholds, loaded on a write enable.
// ----------------------------------------------------------------------------
module bcc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [bcc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [bcc_pkg::ThreshWidth-1:0]   csr_write_data,
   output bcc_pkg::csr_type                      csr
);
   import bcc_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE:   csr_in.debounce_ticks      = csr_write_data;
            CSR_LONG:       csr_in.long_ticks          = csr_write_data;
            CSR_SUPER_LONG: csr_in.super_long_ticks    = csr_write_data;
            CSR_DOUBLE_WIN: csr_in.double_window_ticks = csr_write_data;
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.debounce_ticks      <= DEBOUNCE_RESET;
         csr_ff.long_ticks          <= LONG_RESET;
         csr_ff.super_long_ticks    <= SUPER_LONG_RESET;
         csr_ff.double_window_ticks <= DOUBLE_WIN_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule
`default_nettype wire

[hw/rtl/bcc_fsm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_fsm: press state machine and tick counter
// Advances one step per tick or read item; reads produce one result.
// ----------------------------------------------------------------------------
module bcc_fsm (
   input  wire logic           clock,
   input  wire logic           reset,
   input  bcc_pkg::csr_type    csr,
   input  bcc_pkg::step_type   step,
   output bcc_pkg::result_type result
);
   import bcc_pkg::*;

   press_state_type         state_ff;
   press_state_type         state_in;
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic [CountWidth-1:0]   count_up;
   logic [CmpWidth-1:0]     count_cmp;
   logic [CmpWidth-1:0]     count_up_cmp;
   logic [CmpWidth-1:0]     debounce_cmp;
   logic [CmpWidth-1:0]     long_cmp;
   logic [CmpWidth-1:0]     super_long_cmp;
   logic [CmpWidth-1:0]     double_win_cmp;

   // saturating increment
   assign count_up = (count_ff == CountMax) ? count_ff : count_ff + CountWidth'(1);

   assign count_cmp      = CmpWidth'(count_ff);
   assign count_up_cmp   = CmpWidth'(count_up);
   assign debounce_cmp   = CmpWidth'(csr.debounce_ticks);
   assign long_cmp       = CmpWidth'(csr.long_ticks);
   assign super_long_cmp = CmpWidth'(csr.super_long_ticks);
   assign double_win_cmp = CmpWidth'(csr.double_window_ticks);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      result.valid     = 1'b0;
      result.key_event = EV_NONE;
      if (step.valid && (step.mode == MODE_READ)) begin
         result.valid = 1'b1;
         case (state_ff)
            ST_PRESSED: begin
               result.key_event = EV_PENDING;
            end
            ST_SUPER_LONG: begin
               result.key_event = EV_SUPER_LONG;
               state_in         = ST_WAIT;
            end
            ST_LONG: begin
               result.key_event = EV_LONG;
               state_in         = ST_WAIT;
            end
            ST_SHORT: begin
               result.key_event = EV_SHORT;
               state_in         = ST_WAIT;
            end
            ST_DOUBLE: begin
               result.key_event = EV_DOUBLE;
               state_in         = ST_WAIT;
            end
            default: begin
               result.key_event = EV_NONE;
            end
         endcase
      end else if (step.valid) begin
         case (state_ff)
            ST_WAIT: begin
               if (step.pressed) begin
                  count_in = '0;
                  state_in = ST_DEBOUNCE;
               end
            end
            ST_DEBOUNCE: begin
               count_in = count_up;
               if (count_up_cmp > debounce_cmp) begin
                  state_in = step.pressed ? ST_PRESSED : ST_WAIT;
               end
            end
            ST_PRESSED: begin
               count_in = count_up;
               if (!step.pressed) begin
                  state_in = ST_RELEASED;
               end
            end
            ST_RELEASED: begin
               if (count_cmp > super_long_cmp) begin
                  state_in = ST_SUPER_LONG;
               end else if (count_cmp > long_cmp) begin
                  state_in = ST_LONG;
               end else begin
                  state_in = ST_CHECK_DOUBLE;
                  count_in = '0;
               end
            end
            ST_CHECK_DOUBLE: begin
               if (!step.pressed) begin
                  count_in = count_up;
                  if (count_up_cmp > double_win_cmp) begin
                     state_in = ST_SHORT;
                  end
               end else begin
                  state_in = ST_WAIT_RELEASE;
                  count_in = '0;
               end
            end
            ST_WAIT_RELEASE: begin
               if (!step.pressed) begin
                  state_in = ST_DOUBLE;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // a read of a finished event consumes it
   a_read_consumes: assert property (@(posedge clock) disable iff (reset)
      (step.valid && (step.mode == MODE_READ) &&
       ((state_ff == ST_SUPER_LONG) || (state_ff == ST_LONG) ||
        (state_ff == ST_SHORT) || (state_ff == ST_DOUBLE)))
      |=> (state_ff == ST_WAIT))
      else $error("finished event not consumed by read");

   // a held event ignores ticks
   a_event_held: assert property (@(posedge clock) disable iff (reset)
      (step.valid && (step.mode == MODE_TICK) &&
       ((state_ff == ST_SUPER_LONG) || (state_ff == ST_LONG) ||
        (state_ff == ST_SHORT) || (state_ff == ST_DOUBLE)))
      |=> ($stable(state_ff) && $stable(count_ff)))
      else $error("held event changed by a tick");

   // counter saturates while the key is held
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (step.valid && (step.mode == MODE_TICK) && (state_ff == ST_PRESSED) &&
       (count_ff == CountMax))
      |=> (count_ff == CountMax))
      else $error("tick counter wrapped");

endmodule
`default_nettype wire

[hw/rtl/button_click_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier: debounced short / long / super-long / double click
// Takes tick items (button sample) and read items; a read returns the event.
// ----------------------------------------------------------------------------
// Result path: a read item goes into the input register, then its result into
//   the result register once that slot is free or draining. Tick items give no result.
// Throughput: one item per cycle unless a read waits on a full result slot; the press
//   state and counter update in the single step between input and result registers.
// Reset: synchronous; state goes to waiting-for-press, counter to zero,
//   thresholds to 20 / 2000 / 5000 / 350 ticks.
// ----------------------------------------------------------------------------
module button_click_classifier (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_mode,
   input  wire logic                                req_button_level,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [bcc_pkg::KeyEventWidth-1:0]        rsp_key_event,
   // threshold registers
   input  wire logic                                csr_write_enable,
   input  wire logic [bcc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [bcc_pkg::ThreshWidth-1:0]     csr_write_data
);
   import bcc_pkg::*;

   csr_type       csr;
   step_type      step;
   result_type    result;

   // input register
   logic          in_valid_ff;
   logic          in_valid_in;
   logic          in_mode_ff;
   logic          in_pressed_ff;
   logic          advance;

   // result register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   key_event_type rsp_key_event_ff;

   // A tick never needs the result slot; a read needs it free or draining.
   assign advance = in_valid_ff &&
                    ((in_mode_ff == MODE_TICK) || !rsp_valid_ff || rsp_ready);

   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload: button is low-active
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff    <= req_mode;
         in_pressed_ff <= !req_button_level;
      end
   end

   assign step.valid   = advance;
   assign step.mode    = in_mode_ff;
   assign step.pressed = in_pressed_ff;

   bcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   bcc_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .step   (step),
      .result (result)
   );

   // result register
   assign rsp_valid_in = result.valid ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_key_event_ff <= result.key_event;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = rsp_key_event_ff;

   // a stalled item stays in the input register
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_mode_ff)))
      else $error("stalled item lost from input register");

   // a read is processed only when the result slot can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites an untaken result");

   // every read processed shows up as a result in the next cycle
   a_read_to_result: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_mode_ff == MODE_READ)) |=> rsp_valid_ff)
      else $error("read item produced no result");

endmodule
`default_nettype wire
